// ===== sv/address_occurrence_table_macros.svh =====
// ---------------------------------------------------------------------------
// Address occurrence table assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_OCCURRENCE_TABLE_MACROS_SVH
`define ADDRESS_OCCURRENCE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset
`define AOT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define AOT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AOT_ASSERT_IMP(label, ante, cons, msg)
`define AOT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/aot_pkg.sv =====
// ---------------------------------------------------------------------------
// Address occurrence table package
// Sizes, status codes and the address byte mask shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aot_pkg;

  // Table geometry
  localparam int ENTRIES     = 64;
  localparam int COUNT_WIDTH = 32;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W      = $clog2(ENTRIES + 1);

  // Fixed field widths
  localparam int ADDR_W   = 48;
  localparam int ABYTES_W = 3;
  localparam int OIDX_W   = 6;
  localparam int OCNT_W   = 32;
  localparam int OUSED_W  = 7;
  localparam int STAT_W   = 3;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_HIT        = 3'd0,
    STAT_NEW        = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_READ_OK    = 3'd3,
    STAT_READ_EMPTY = 3'd4
  } aot_status_t;

  // Item modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // Low-byte mask; zero bytes acts as one, seven as six
  function automatic logic [ADDR_W-1:0] byte_mask(input logic [ABYTES_W-1:0] n);
    logic [ADDR_W-1:0] m;
    m = '0;
    case (n)
      3'd0, 3'd1: m = 48'h0000_0000_00FF;
      3'd2:       m = 48'h0000_0000_FFFF;
      3'd3:       m = 48'h0000_00FF_FFFF;
      3'd4:       m = 48'h0000_FFFF_FFFF;
      3'd5:       m = 48'h00FF_FFFF_FFFF;
      default:    m = 48'hFFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/aot_ram.sv =====
// ---------------------------------------------------------------------------
// Address occurrence table RAM
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/address_occurrence_table.sv =====
// ---------------------------------------------------------------------------
// Address occurrence table
// Counts occurrences of distinct addresses in order of first appearance.
// ---------------------------------------------------------------------------
// Usage: an item on the in_ channel either records an address (mode 0) or
// reads one entry by index (mode 1); each item gives exactly one result
// item on the out_ channel with status, entry index, key, count and fill.
// A record scans the used entries through the key and count memories, one
// entry per cycle over the single read port, and stops at the first match;
// a miss scans every used entry. A read of an index below the fill count
// fetches that entry, and one at or past the fill count gives an empty
// result without a memory read. in_ready is low from accept until the
// result is handed to the output register and rises the cycle after, so
// one item is in work at a time. The output register holds a result while
// out_ready is low; a finished result waits there while the next item is
// accepted, and a later result waits in the block until the register frees.
// Reset clears the fill count and sets address_bytes to 6; table contents
// are not cleared, as only entries below the fill count are ever read. The
// cfg_ APB port writes address_bytes at byte address 0; the user must write
// it only while the block is idle, and the block itself does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "address_occurrence_table_macros.svh"

module address_occurrence_table
  import aot_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input item channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [OIDX_W-1:0]   in_read_index,
  // Result item channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [OIDX_W-1:0]   out_entry_index,
  output logic [ADDR_W-1:0]   out_entry_address,
  output logic [OCNT_W-1:0]   out_entry_count,
  output logic [OUSED_W-1:0]  out_entries_used,
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_PUSH
  } state_t;

  state_t                 state_r;
  logic [ABYTES_W-1:0]    abytes_r;
  logic [ADDR_W-1:0]      addr_r;
  logic [USED_W-1:0]      used_r;
  logic [USED_W-1:0]      scan_ptr_r;
  logic                   cmp_valid_r;
  logic [IDX_W-1:0]       cmp_idx_r;

  aot_status_t            res_status_r;
  logic [OIDX_W-1:0]      res_idx_r;
  logic [ADDR_W-1:0]      res_addr_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;

  logic                   out_valid_r;
  aot_status_t            out_status_r;
  logic [OIDX_W-1:0]      out_idx_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [OCNT_W-1:0]      out_cnt_r;
  logic [OUSED_W-1:0]     out_used_r;

  logic [ADDR_W-1:0]      mask;
  logic [ADDR_W-1:0]      key_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   hit;
  logic                   scan_more;
  logic                   table_full;
  logic                   in_fire;
  logic                   read_ok;
  logic                   cfg_wr;
  logic                   key_we;
  logic                   cnt_we;
  logic [IDX_W-1:0]       waddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata;
  logic [IDX_W-1:0]       raddr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32-ABYTES_W){1'b0}}, abytes_r};

  // Handshakes
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign read_ok  = ({{(USED_W > OIDX_W ? USED_W - OIDX_W : 0){1'b0}}, in_read_index}
                     < {{(OIDX_W > USED_W ? OIDX_W - USED_W : 0){1'b0}}, used_r});

  // Compare and count update of the entry read last cycle
  assign mask       = byte_mask(abytes_r);
  assign hit        = (state_r == ST_SCAN) && cmp_valid_r && ((key_rd & mask) == addr_r);
  assign cnt_inc    = (cnt_rd == {COUNT_WIDTH{1'b1}}) ? cnt_rd : cnt_rd + 1'b1;
  assign scan_more  = (scan_ptr_r < used_r);
  assign table_full = (used_r == USED_W'(ENTRIES));

  // Memory controls: read index on idle, scan pointer while scanning
  always_comb begin
    raddr     = (state_r == ST_IDLE) ? IDX_W'(in_read_index) : IDX_W'(scan_ptr_r);
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = IDX_W'(used_r);
    cnt_wdata = COUNT_WIDTH'(1);
    if (state_r == ST_SCAN) begin
      if (hit) begin
        cnt_we    = 1'b1;
        waddr     = cmp_idx_r;
        cnt_wdata = cnt_inc;
      end else if (!scan_more && !table_full) begin
        key_we = 1'b1;
        cnt_we = 1'b1;
      end
    end
  end

  aot_ram #(.WIDTH(ADDR_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (addr_r),
    .raddr (raddr),
    .rdata (key_rd)
  );

  aot_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  // Sequencer, table fill and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      abytes_r    <= ABYTES_W'(6);
      used_r      <= '0;
      scan_ptr_r  <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && !cfg_paddr[2]) begin
        abytes_r <= cfg_pwdata[ABYTES_W-1:0];
      end
      // drop the shown result once taken, unless a new one replaces it
      if (out_valid_r && out_ready && state_r != ST_PUSH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            addr_r      <= in_address & byte_mask(abytes_r);
            res_idx_r   <= in_read_index;
            scan_ptr_r  <= '0;
            cmp_valid_r <= 1'b0;
            if (in_mode == MODE_RECORD) begin
              state_r <= ST_SCAN;
            end else if (read_ok) begin
              state_r <= ST_READ;
            end else begin
              res_status_r <= STAT_READ_EMPTY;
              res_addr_r   <= '0;
              res_cnt_r    <= '0;
              state_r      <= ST_PUSH;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_status_r <= STAT_HIT;
            res_idx_r    <= OIDX_W'(cmp_idx_r);
            res_addr_r   <= key_rd;
            res_cnt_r    <= cnt_inc;
            cmp_valid_r  <= 1'b0;
            state_r      <= ST_PUSH;
          end else if (scan_more) begin
            // advance to the next used entry
            cmp_valid_r <= 1'b1;
            cmp_idx_r   <= IDX_W'(scan_ptr_r);
            scan_ptr_r  <= scan_ptr_r + 1'b1;
          end else if (table_full) begin
            res_status_r <= STAT_FULL;
            res_idx_r    <= '0;
            res_addr_r   <= '0;
            res_cnt_r    <= '0;
            cmp_valid_r  <= 1'b0;
            state_r      <= ST_PUSH;
          end else begin
            // append the new key with count one
            res_status_r <= STAT_NEW;
            res_idx_r    <= OIDX_W'(used_r);
            res_addr_r   <= addr_r;
            res_cnt_r    <= COUNT_WIDTH'(1);
            used_r       <= used_r + 1'b1;
            cmp_valid_r  <= 1'b0;
            state_r      <= ST_PUSH;
          end
        end
        ST_READ: begin
          res_status_r <= STAT_READ_OK;
          res_addr_r   <= key_rd;
          res_cnt_r    <= cnt_rd;
          state_r      <= ST_PUSH;
        end
        ST_PUSH: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_r;
            out_addr_r   <= res_addr_r;
            out_cnt_r    <= OCNT_W'(res_cnt_r);
            out_used_r   <= OUSED_W'(used_r);
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_index   = out_idx_r;
  assign out_entry_address = out_addr_r;
  assign out_entry_count   = out_cnt_r;
  assign out_entries_used  = out_used_r;

  // Checks
  `AOT_ASSERT_IMP(a_used_bound, 1'b1, used_r <= USED_W'(ENTRIES), "fill count beyond table depth")
  `AOT_ASSERT_IMP(a_used_step, used_r != $past(used_r), used_r == $past(used_r) + 1'b1, "fill count moved by other than one")
  `AOT_ASSERT_NXT(a_hit_result, hit, state_r == ST_PUSH && res_status_r == STAT_HIT, "match not turned into a hit result")
  `AOT_ASSERT_IMP(a_new_index, out_valid_r && out_status_r == STAT_NEW, OUSED_W'(out_idx_r) + 1'b1 == out_used_r, "new entry index does not match fill count")

endmodule

// ===== verif/address_occurrence_table_tb.sv =====
// ---------------------------------------------------------------------------
// Address occurrence table testbench
// Drives record and read items into the table, predicts every result item
// from a local copy of the keys, counts and fill level, and checks each
// result field by field. Covers every address width setting, a full table,
// long output stalls and random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_occurrence_table_tb;
  import aot_pkg::*;

  localparam int          CYCLE_LIMIT       = 400000;
  localparam int          LONG_HOLD_CYCLES  = 300;
  localparam int          SETTLE_CYCLES     = 8;
  localparam int          MAX_REPORTS       = 10;
  localparam logic [2:0]  REG_ADDRESS_BYTES = 3'd0;

  // One expected result item
  typedef struct packed {
    aot_status_t         status;
    logic [OIDX_W-1:0]   index;
    logic [ADDR_W-1:0]   address;
    logic [OCNT_W-1:0]   count;
    logic [OUSED_W-1:0]  used;
  } table_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_mode = MODE_RECORD;
  logic [ADDR_W-1:0]   in_address = '0;
  logic [OIDX_W-1:0]   in_read_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [OIDX_W-1:0]   out_entry_index;
  logic [ADDR_W-1:0]   out_entry_address;
  logic [OCNT_W-1:0]   out_entry_count;
  logic [OUSED_W-1:0]  out_entries_used;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [2:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // Local copy of the table
  logic [ADDR_W-1:0]       table_keys [ENTRIES];
  logic [COUNT_WIDTH-1:0]  table_counts [ENTRIES];
  int                      table_fill = 0;
  logic [ABYTES_W-1:0]     tracked_address_bytes = 3'd6;

  table_result_t       expected_results [$];
  logic [ADDR_W-1:0]   recorded_addresses [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   cycle_count = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   mismatch_count = 0;
  int   status_seen [5] = '{default: 0};

  address_occurrence_table DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_address        (in_address),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_entry_index   (out_entry_index),
    .out_entry_address (out_entry_address),
    .out_entry_count   (out_entry_count),
    .out_entries_used  (out_entries_used),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results pending", cycle_count,
               expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Keep only the low address bytes; zero acts as one, seven as six
  function automatic logic [ADDR_W-1:0] key_mask(input logic [ABYTES_W-1:0] nbytes);
    int           n;
    logic [ADDR_W:0] wide;
    n = nbytes;
    if (n < 1) n = 1;
    if (n > 6) n = 6;
    wide = (49'd1 << (8 * n)) - 49'd1;
    return wide[ADDR_W-1:0];
  endfunction

  // Apply one item to the local table and return the result it yields
  function automatic table_result_t predict_table_result(input logic mode,
      input logic [ADDR_W-1:0] addr, input logic [OIDX_W-1:0] ridx);
    table_result_t     r;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] key;
    int                hit;
    int                i;
    r = '0;
    hit = -1;
    mask = key_mask(tracked_address_bytes);
    key = addr & mask;
    if (mode == MODE_READ) begin
      r.index = ridx;
      if (int'(ridx) < table_fill) begin
        r.status = STAT_READ_OK;
        r.address = table_keys[ridx];
        r.count = table_counts[ridx][OCNT_W-1:0];
      end else begin
        r.status = STAT_READ_EMPTY;
      end
    end else begin
      for (i = 0; i < table_fill; i++) begin
        if (hit < 0 && (table_keys[i] & mask) == key) hit = i;
      end
      if (hit >= 0) begin
        if (table_counts[hit] != '1) table_counts[hit] = table_counts[hit] + 1'b1;
        r.status = STAT_HIT;
        r.index = hit[OIDX_W-1:0];
        r.address = table_keys[hit];
        r.count = table_counts[hit][OCNT_W-1:0];
      end else if (table_fill >= ENTRIES) begin
        r.status = STAT_FULL;
      end else begin
        table_keys[table_fill] = key;
        table_counts[table_fill] = COUNT_WIDTH'(1);
        r.status = STAT_NEW;
        r.index = table_fill[OIDX_W-1:0];
        r.address = key;
        r.count = OCNT_W'(1);
        table_fill++;
      end
    end
    r.used = table_fill[OUSED_W-1:0];
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[ADDR_W-1:0];
  endfunction

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_item(input logic mode, input logic [ADDR_W-1:0] addr,
      input logic [OIDX_W-1:0] ridx);
    table_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_address <= addr;
    in_read_index <= ridx;
    do @(posedge clk); while (!in_ready);
    want = predict_table_result(mode, addr, ridx);
    expected_results = {expected_results, want};
    if (mode == MODE_RECORD && recorded_addresses.size() < 256)
      recorded_addresses = {recorded_addresses, addr};
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the address width; call only while the table is idle
  task automatic write_address_bytes(input logic [ABYTES_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_ADDRESS_BYTES;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracked_address_bytes = value;
  endtask

  // Mix reads, repeats of known addresses and fresh addresses
  task automatic send_random_item();
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
    int                pick;
    pick = $urandom_range(99);
    mask = key_mask(tracked_address_bytes);
    if (pick < 20) begin
      if (table_fill > 0 && $urandom_range(1))
        send_item(MODE_READ, rand_address(), OIDX_W'($urandom_range(table_fill - 1)));
      else
        send_item(MODE_READ, rand_address(), OIDX_W'($urandom_range(63)));
    end else if (pick < 30 || recorded_addresses.size() == 0) begin
      send_item(MODE_RECORD, rand_address(), OIDX_W'($urandom_range(63)));
    end else begin
      addr = recorded_addresses[$urandom_range(recorded_addresses.size() - 1)];
      // Scramble the bytes above the compared width
      if ($urandom_range(1)) addr = (addr & mask) | (rand_address() & ~mask);
      send_item(MODE_RECORD, addr, OIDX_W'($urandom_range(63)));
    end
  endtask

  // Drive out_ready: long hold on request, else random stalls
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void report_field(input string field, input logic [63:0] want,
      input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("result %0d: %s expected %h, got %h", results_checked, field, want, got);
  endfunction

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: status %0d index %0d",
                   results_checked, out_status, out_entry_index);
      end else begin
        want = expected_results.pop_front();
        if (int'(want.status) < 5) status_seen[want.status]++;
        if (out_status !== want.status) report_field("status", want.status, out_status);
        if (out_entry_index !== want.index)
          report_field("entry_index", want.index, out_entry_index);
        if (out_entry_address !== want.address)
          report_field("entry_address", want.address, out_entry_address);
        if (out_entry_count !== want.count)
          report_field("entry_count", want.count, out_entry_count);
        if (out_entries_used !== want.used)
          report_field("entries_used", want.used, out_entries_used);
      end
    end
  end

  // Extremes of the fields, hits, new entries and reads past the fill level
  task automatic test_directed_entries();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(MODE_READ, '0, 6'd0);
    send_item(MODE_RECORD, 48'h0000_0000_0000, 6'd0);
    send_item(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 6'h3F);
    send_item(MODE_RECORD, 48'hFFFF_FFFF_FFFF, 6'd0);
    send_item(MODE_RECORD, 48'h0000_0000_0000, 6'h2A);
    send_item(MODE_RECORD, 48'hA5A5_5A5A_C3C3, 6'd0);
    send_item(MODE_READ, 48'hFFFF_FFFF_FFFF, 6'd0);
    send_item(MODE_READ, 48'hFFFF_FFFF_FFFF, 6'd1);
    send_item(MODE_READ, '0, 6'd2);
    send_item(MODE_READ, '0, 6'd3);
    send_item(MODE_READ, 48'h1234_5678_9ABC, 6'h3F);
    send_item(MODE_RECORD, 48'h0123_4567_89AB, 6'h3F);
    send_item(MODE_RECORD, 48'h5A5A_A5A5_3C3C, 6'h15);
    wait_for_results();
  endtask

  // Narrow and widen the compared bytes, including both out-of-range codes
  task automatic test_address_width();
    write_address_bytes(3'd4);
    send_item(MODE_RECORD, 48'hBEEF_FFFF_FFFF, 6'd0);
    send_item(MODE_RECORD, 48'h1234_0000_0000, 6'd0);
    send_item(MODE_RECORD, 48'hFFFF_A5A5_3C3C, 6'd0);
    wait_for_results();
    write_address_bytes(3'd0);
    send_item(MODE_RECORD, 48'h0000_0000_00AB, 6'd0);
    send_item(MODE_RECORD, 48'h0000_0000_0077, 6'd0);
    send_item(MODE_RECORD, 48'hFFFF_FFFF_FF77, 6'd0);
    wait_for_results();
    write_address_bytes(3'd7);
    send_item(MODE_RECORD, 48'h0000_0000_0077, 6'd0);
    send_item(MODE_RECORD, 48'hFF00_0000_0077, 6'd0);
    send_item(MODE_READ, '0, 6'd6);
    wait_for_results();
    write_address_bytes(3'd1);
    send_item(MODE_RECORD, 48'h1111_1111_11C3, 6'd0);
    wait_for_results();
  endtask

  task automatic test_random_phase(input int count, input int idle_pct,
      input int stall_pct, input logic [ABYTES_W-1:0] nbytes);
    write_address_bytes(nbytes);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
    wait_for_results();
  endtask

  // Hold the output off while items keep coming, then drain completely
  task automatic test_backpressure();
    write_address_bytes(3'd3);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (40) send_random_item();
    wait_for_results();
  endtask

  // Fill every entry, then offer new addresses to a full table
  task automatic test_table_full();
    write_address_bytes(3'd6);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    while (table_fill < ENTRIES)
      send_item(MODE_RECORD, rand_address(), OIDX_W'($urandom_range(63)));
    repeat (8) send_item(MODE_RECORD, rand_address(), '0);
    send_item(MODE_READ, '0, 6'h3F);
    send_item(MODE_READ, '0, 6'd0);
    wait_for_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_entries();
    test_address_width();
    test_random_phase(140, 0, 0, 3'd6);
    test_random_phase(140, 53, 0, 3'd2);
    test_random_phase(140, 0, 53, 3'd4);
    test_random_phase(140, 11, 11, 3'd5);
    test_backpressure();
    test_table_full();
    test_random_phase(60, 11, 11, 3'd6);
    $display("ran %0d items through all address widths; %0d results checked",
             items_sent, results_checked);
    $display("hits %0d, new %0d, full drops %0d, reads %0d, empty reads %0d, mismatches %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/aot_pkg.sv
sv/aot_ram.sv
sv/address_occurrence_table.sv
verif/address_occurrence_table_tb.sv
